[sv/sttd_pkg.sv]
// ----------------------------------------------------------------------------
// Strain touch threshold detector package
// Shared widths, command codes, register indexes and reset constants.
// ----------------------------------------------------------------------------
package sttd_pkg;

    localparam int WINDOW_DEFAULT       = 8;
    localparam int THRESH_BLOCK_DEFAULT = 16;

    localparam int SAMPLE_W = 10;
    localparam int ADJ_W    = 11;
    localparam int CMD_W    = 2;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_SAMPLE   = 2'd0;
    localparam cmd_t CMD_SET_ZERO = 2'd1;
    localparam cmd_t CMD_PRIME    = 2'd2;

    typedef logic reg_index_t;

    localparam reg_index_t REG_TRIGGER_ENABLE = 1'b0;
    localparam reg_index_t REG_NEGATIVE_LIMIT = 1'b1;

    localparam logic               TRIGGER_ENABLE_RESET = 1'b1;
    localparam logic signed [10:0] NEG_LIMIT_RESET      = -11'sd100;

endpackage

[sv/strain_touch_threshold_detector_unit.sv]
// ----------------------------------------------------------------------------
// Strain touch threshold detector
// Moving-average strain detector with block-averaged threshold and a
// negative limit; the sample window is held in a synchronous memory.
// ----------------------------------------------------------------------------
// The result is registered in the s1, s2 and output stages in that order.
// Throughput: one transaction per cycle while the output is not stalled,
// set by the window memory that is read one entry ahead of the write
// pointer and written once per sample.
// Back pressure on the output stalls a three-stage pipeline stage by stage.
// Reset clears the valid flags, not the window memory; no clearing pass is needed.
// ----------------------------------------------------------------------------
module strain_touch_threshold_detector_unit #(
    parameter int WINDOW       = sttd_pkg::WINDOW_DEFAULT,
    parameter int THRESH_BLOCK = sttd_pkg::THRESH_BLOCK_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // strain_sample, threshold_sample, zero_value
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // adjusted, threshold_average, touched
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    localparam int SW     = sttd_pkg::SAMPLE_W;
    localparam int PTR_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(THRESH_BLOCK);
    localparam int WSUM_W = SW + $clog2(WINDOW);
    localparam int TSUM_W = SW + $clog2(THRESH_BLOCK);

    logic               trig_en_reg;
    logic signed [10:0] neg_limit_reg;

    logic               s_fire;
    sttd_pkg::cmd_t     cmd;
    logic [SW-1:0]      strain;
    logic [SW-1:0]      thr;
    logic [SW-1:0]      zval;

    logic [SW-1:0]      mem [WINDOW];
    logic [SW-1:0]      rd_data_reg;
    logic               wr_en;

    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [WINDOW-1:0]  valid_reg, valid_next;
    logic [WSUM_W-1:0]  wsum_reg, wsum_next;
    logic [SW-1:0]      base_reg, base_next;
    logic [TSUM_W-1:0]  tsum_reg, tsum_next, tsum_add;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SW-1:0]      old_entry;
    logic               thr_acc;
    logic               blk_done;

    logic               s1_valid_reg, s1_sample_reg, s1_blk_reg;
    logic [WSUM_W-1:0]  s1_wsum_reg;
    logic [TSUM_W-1:0]  s1_tblk_reg;
    logic [SW-1:0]      s1_base_reg;

    logic               s2_valid_reg, s2_sample_reg, s2_blk_reg;
    logic [SW-1:0]      s2_base_reg;
    logic [SW-1:0]      wq, tq;

    logic               out_valid_reg;
    logic [23:0]        out_data_reg;
    logic [SW-1:0]      avg_reg, avg_next;
    logic signed [11:0] adj_full;
    logic               touched;

    logic               ready1, ready2, ready3;

    assign cmd    = s_axis_tuser;
    assign strain = s_axis_tdata[9:0];
    assign thr    = s_axis_tdata[19:10];
    assign zval   = s_axis_tdata[29:20];

    assign ready3        = !out_valid_reg || m_axis_tready;
    assign ready2        = !s2_valid_reg || ready3;
    assign ready1        = !s1_valid_reg || ready2;
    assign s_axis_tready = ready1;
    assign s_fire        = s_axis_tvalid && ready1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_en_reg   <= sttd_pkg::TRIGGER_ENABLE_RESET;
            neg_limit_reg <= sttd_pkg::NEG_LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sttd_pkg::REG_TRIGGER_ENABLE: trig_en_reg   <= cfg_data[0];
                sttd_pkg::REG_NEGATIVE_LIMIT: neg_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        ptr_next   = ptr_reg;
        valid_next = valid_reg;
        wsum_next  = wsum_reg;
        base_next  = base_reg;
        tsum_next  = tsum_reg;
        cnt_next   = cnt_reg;
        wr_en      = 1'b0;
        thr_acc    = 1'b0;
        blk_done   = 1'b0;
        old_entry  = valid_reg[ptr_reg] ? rd_data_reg : base_reg;
        tsum_add   = tsum_reg + TSUM_W'(thr);
        if (s_fire)
        begin
            case (cmd)
                sttd_pkg::CMD_SAMPLE:
                begin
                    wsum_next           = wsum_reg - WSUM_W'(old_entry) + WSUM_W'(strain);
                    wr_en               = 1'b1;
                    valid_next[ptr_reg] = 1'b1;
                    ptr_next            = (ptr_reg == PTR_W'(WINDOW - 1)) ?
                                          '0 : ptr_reg + 1'b1;
                    thr_acc             = 1'b1;
                end
                sttd_pkg::CMD_SET_ZERO:
                begin
                    base_next  = zval;
                    valid_next = '0;
                    wsum_next  = WSUM_W'(zval) * WSUM_W'(WINDOW);
                end
                sttd_pkg::CMD_PRIME:
                begin
                    thr_acc = 1'b1;
                end
                default: ;
            endcase
        end
        if (thr_acc)
        begin
            if (cnt_reg == CNT_W'(THRESH_BLOCK - 1))
            begin
                blk_done  = 1'b1;
                tsum_next = '0;
                cnt_next  = '0;
            end
            else
            begin
                tsum_next = tsum_add;
                cnt_next  = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= strain;
        end
        rd_data_reg <= mem[ptr_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            valid_reg <= '0;
            wsum_reg  <= '0;
            base_reg  <= '0;
            tsum_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            valid_reg <= valid_next;
            wsum_reg  <= wsum_next;
            base_reg  <= base_next;
            tsum_reg  <= tsum_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (ready2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_sample_reg <= (cmd == sttd_pkg::CMD_SAMPLE);
            s1_blk_reg    <= blk_done;
            s1_wsum_reg   <= wsum_next;
            s1_tblk_reg   <= tsum_add;
            s1_base_reg   <= base_next;
        end
        if (ready2 && s1_valid_reg)
        begin
            s2_sample_reg <= s1_sample_reg;
            s2_blk_reg    <= s1_blk_reg;
            s2_base_reg   <= s1_base_reg;
        end
    end

    sttd_recip_div #(
        .DIVISOR    (WINDOW),
        .DIVIDEND_W (WSUM_W),
        .QUOTIENT_W (SW)
    ) u_window_div (
        .clk      (clk),
        .en       (ready2 && s1_valid_reg),
        .dividend (s1_wsum_reg),
        .quotient (wq)
    );

    sttd_recip_div #(
        .DIVISOR    (THRESH_BLOCK),
        .DIVIDEND_W (TSUM_W),
        .QUOTIENT_W (SW)
    ) u_thresh_div (
        .clk      (clk),
        .en       (ready2 && s1_valid_reg),
        .dividend (s1_tblk_reg),
        .quotient (tq)
    );

    always_comb
    begin
        avg_next = s2_blk_reg ? tq : avg_reg;
        adj_full = $signed({2'b00, wq}) - $signed({2'b00, s2_base_reg});
        touched  = s2_sample_reg && trig_en_reg &&
                   ((adj_full >= $signed({2'b00, avg_next})) ||
                    (adj_full <= $signed({neg_limit_reg[10], neg_limit_reg})));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            avg_reg       <= '0;
        end
        else
        begin
            if (ready3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (ready3 && s2_valid_reg)
            begin
                avg_reg <= avg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready3 && s2_valid_reg)
        begin
            out_data_reg <= {2'b00, touched, avg_next, adj_full[10:0]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_zero_clears_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && cmd == sttd_pkg::CMD_SET_ZERO) |=> (valid_reg == '0))
        else $error("Set-zero transaction did not invalidate the window.");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(WINDOW - 1))
        else $error("Window pointer out of range.");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(THRESH_BLOCK - 1))
        else $error("Threshold block count out of range.");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("Input stalled while the pipeline has room.");
`endif

endmodule

[sv/sttd_recip_div.sv]
// ----------------------------------------------------------------------------
// Constant divider stage
// Divides an unsigned value by a constant through a registered multiply by
// the rounded-up reciprocal; the result is exact over the whole input range.
// ----------------------------------------------------------------------------
module sttd_recip_div #(
    parameter int DIVISOR    = sttd_pkg::WINDOW_DEFAULT,
    parameter int DIVIDEND_W = sttd_pkg::SAMPLE_W + $clog2(sttd_pkg::WINDOW_DEFAULT),
    parameter int QUOTIENT_W = sttd_pkg::SAMPLE_W
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic [QUOTIENT_W-1:0] quotient
);

    localparam int              SHIFT  = DIVIDEND_W + $clog2(DIVISOR);
    localparam int              MULT_W = DIVIDEND_W + 2;
    localparam int              PROD_W = DIVIDEND_W + MULT_W;
    localparam longint unsigned MULT   =
        ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= PROD_W'(dividend) * PROD_W'(MULT_W'(MULT));
        end
    end

    assign quotient = prod_reg[SHIFT +: QUOTIENT_W];

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Strain touch threshold detector testbench
// Drives command, sample and register traffic into the detector, tracks the
// moving window, zero baseline and threshold blocks in its own copy of the
// state, and checks every output transaction field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int             WIN         = sttd_pkg::WINDOW_DEFAULT;
    localparam int             THR_BLOCK   = sttd_pkg::THRESH_BLOCK_DEFAULT;
    localparam int             CYCLE_LIMIT = 300000;
    localparam sttd_pkg::cmd_t CMD_UNUSED  = 2'd3;

    typedef struct packed {
        logic signed [sttd_pkg::ADJ_W-1:0]    adjusted;
        logic        [sttd_pkg::SAMPLE_W-1:0] thr_average;
        logic                                 touched;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [10:0] cfg_data = '0;

    // Detector state as seen by the predictor.
    logic [sttd_pkg::SAMPLE_W-1:0]     win_mem [WIN];
    logic [2:0]                        win_ptr;
    logic [12:0]                       win_total;
    logic [sttd_pkg::SAMPLE_W-1:0]     zero_ref;
    logic [13:0]                       thr_total;
    logic [4:0]                        thr_cnt;
    logic [sttd_pkg::SAMPLE_W-1:0]     thr_mean;
    logic                              en_trig;
    logic signed [sttd_pkg::ADJ_W-1:0] neg_lim;

    reading_t readings_due [$];
    reading_t want;
    int       fail_count = 0;
    bit       gaps_on = 1'b0;
    bit       stall_on = 1'b0;
    int       burst_left = 0;
    int       stall_run = 0;
    bit       stall_level = 1'b1;
    int       thr_ceiling = 1023;

    strain_touch_threshold_detector_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    task automatic clear_detector_state();
        foreach (win_mem[i])
        begin
            win_mem[i] = '0;
        end
        win_ptr   = '0;
        win_total = '0;
        zero_ref  = '0;
        thr_total = '0;
        thr_cnt   = '0;
        thr_mean  = '0;
        en_trig   = sttd_pkg::TRIGGER_ENABLE_RESET;
        neg_lim   = sttd_pkg::NEG_LIMIT_RESET;
    endtask

    function automatic void add_threshold(input logic [sttd_pkg::SAMPLE_W-1:0] thr);
        if (thr_cnt == THR_BLOCK - 1)
        begin
            thr_mean  = 10'((int'(thr_total) + int'(thr)) / THR_BLOCK);
            thr_total = '0;
            thr_cnt   = '0;
        end
        else
        begin
            thr_total = thr_total + thr;
            thr_cnt   = thr_cnt + 1'b1;
        end
    endfunction

    function automatic reading_t detect_touch(input sttd_pkg::cmd_t cmd,
                                              input logic [sttd_pkg::SAMPLE_W-1:0] strain,
                                              input logic [sttd_pkg::SAMPLE_W-1:0] thr,
                                              input logic [sttd_pkg::SAMPLE_W-1:0] zval);
        reading_t r;
        int       adj;
        if (cmd == sttd_pkg::CMD_SAMPLE)
        begin
            win_total        = win_total - win_mem[win_ptr] + strain;
            win_mem[win_ptr] = strain;
            win_ptr          = win_ptr + 1'b1;
            add_threshold(thr);
        end
        else if (cmd == sttd_pkg::CMD_SET_ZERO)
        begin
            zero_ref = zval;
            foreach (win_mem[i])
            begin
                win_mem[i] = zval;
            end
            win_total = 13'(int'(zval) * WIN);
        end
        else if (cmd == sttd_pkg::CMD_PRIME)
        begin
            add_threshold(thr);
        end
        adj           = int'(win_total) / WIN - int'(zero_ref);
        r.adjusted    = adj[sttd_pkg::ADJ_W-1:0];
        r.thr_average = thr_mean;
        r.touched     = (cmd == sttd_pkg::CMD_SAMPLE) && en_trig &&
                        (adj >= int'(thr_mean) || adj <= int'(neg_lim));
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (readings_due.size() == 0)
                begin
                    fail_count++;
                    $error("output transaction with no expected result: %h", m_axis_tdata);
                end
                else
                begin
                    want = readings_due.pop_front();
                    if (m_axis_tdata[10:0] !== want.adjusted)
                    begin
                        fail_count++;
                        $error("adjusted: expected %0d, actual %0d", want.adjusted,
                               $signed(m_axis_tdata[10:0]));
                    end
                    if (m_axis_tdata[20:11] !== want.thr_average)
                    begin
                        fail_count++;
                        $error("threshold_average: expected %0d, actual %0d",
                               want.thr_average, m_axis_tdata[20:11]);
                    end
                    if (m_axis_tdata[21] !== want.touched)
                    begin
                        fail_count++;
                        $error("touched: expected %0d, actual %0d", want.touched,
                               m_axis_tdata[21]);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sttd_pkg::REG_TRIGGER_ENABLE)
                begin
                    en_trig = cfg_data[0];
                end
                else
                begin
                    neg_lim = cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                readings_due.push_back(detect_touch(s_axis_tuser, s_axis_tdata[9:0],
                                                    s_axis_tdata[19:10],
                                                    s_axis_tdata[29:20]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!stall_on)
        begin
            m_axis_tready <= 1'b1;
        end
        else
        begin
            if (stall_run == 0)
            begin
                stall_level = ($urandom_range(0, 99) < 60);
                stall_run   = stall_level ? $urandom_range(1, 10) : $urandom_range(1, 7);
            end
            stall_run--;
            m_axis_tready <= stall_level;
        end
    end

    task automatic send_item(input sttd_pkg::cmd_t cmd,
                             input logic [sttd_pkg::SAMPLE_W-1:0] strain,
                             input logic [sttd_pkg::SAMPLE_W-1:0] thr,
                             input logic [sttd_pkg::SAMPLE_W-1:0] zval);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, zval, thr, strain};
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left--;
        end
    endtask

    task automatic write_reg(input sttd_pkg::reg_index_t idx, input logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (readings_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random_item();
        int                            pick;
        int                            center;
        sttd_pkg::cmd_t                cmd;
        logic [sttd_pkg::SAMPLE_W-1:0] strain;
        logic [sttd_pkg::SAMPLE_W-1:0] thr;
        logic [sttd_pkg::SAMPLE_W-1:0] zval;
        pick   = $urandom_range(0, 99);
        cmd    = (pick < 68) ? sttd_pkg::CMD_SAMPLE : (pick < 78) ? sttd_pkg::CMD_SET_ZERO :
                 (pick < 94) ? sttd_pkg::CMD_PRIME : CMD_UNUSED;
        strain = 10'($urandom);
        thr    = 10'($urandom);
        zval   = 10'($urandom);
        pick   = $urandom_range(0, 9);
        if (pick < 6)
        begin
            center = int'(zero_ref) + int'($urandom_range(0, 400)) - 200;
            strain = (center < 0) ? 10'd0 : (center > 1023) ? 10'd1023 : 10'(center);
        end
        else if (pick == 6)
        begin
            strain = '0;
        end
        else if (pick == 7)
        begin
            strain = '1;
        end
        if ($urandom_range(0, 4) != 0)
        begin
            thr = 10'($urandom_range(0, thr_ceiling));
        end
        send_item(cmd, strain, thr, zval);
    endtask

    task automatic run_random_phase(input int count);
        gaps_on     = $urandom_range(0, 2) != 0;
        stall_on    = $urandom_range(0, 2) != 0;
        thr_ceiling = ($urandom_range(0, 2) == 0) ? 60 :
                      ($urandom_range(0, 1) == 0) ? 300 : 1023;
        repeat (count) send_random_item();
    endtask

    task automatic test_after_reset();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        send_item(sttd_pkg::CMD_SAMPLE, 10'd0, 10'd0, 10'd0);
        send_item(CMD_UNUSED, 10'h3FF, 10'h3FF, 10'h3FF);
        send_item(sttd_pkg::CMD_PRIME, 10'd0, 10'd1023, 10'd0);
    endtask

    task automatic test_field_extremes();
        send_item(sttd_pkg::CMD_SAMPLE, 10'd1023, 10'd1023, 10'd0);
        send_item(sttd_pkg::CMD_SET_ZERO, 10'd0, 10'd0, 10'd1023);
        send_item(sttd_pkg::CMD_SAMPLE, 10'd0, 10'd0, 10'd0);
        send_item(sttd_pkg::CMD_SAMPLE, 10'd0, 10'd1023, 10'd1023);
        send_item(CMD_UNUSED, 10'd0, 10'd0, 10'd0);
        send_item(sttd_pkg::CMD_SET_ZERO, 10'h3FF, 10'h3FF, 10'd0);
        send_item(sttd_pkg::CMD_SAMPLE, 10'd1023, 10'd0, 10'd0);
        send_item(sttd_pkg::CMD_PRIME, 10'h2AA, 10'h155, 10'h2AA);
        send_item(sttd_pkg::CMD_SET_ZERO, 10'd0, 10'd0, 10'd512);
        send_item(sttd_pkg::CMD_SAMPLE, 10'd511, 10'd7, 10'd0);
        wait_idle();
        write_reg(sttd_pkg::REG_TRIGGER_ENABLE, 11'd0);
        send_item(sttd_pkg::CMD_SAMPLE, 10'd1023, 10'd0, 10'd0);
        send_item(sttd_pkg::CMD_SAMPLE, 10'd0, 10'd0, 10'd0);
        wait_idle();
        write_reg(sttd_pkg::REG_TRIGGER_ENABLE, 11'd1);
        send_item(sttd_pkg::CMD_SAMPLE, 10'd0, 10'd0, 10'd0);
        wait_idle();
    endtask

    task automatic test_limit_settings();
        logic [10:0] limit;
        logic        enable;
        for (int i = 0; i < 8; i++)
        begin
            case (i)
                0:       limit = -11'sd1023;
                1:       limit = 11'h400;
                2:       limit = 11'd0;
                3:       limit = 11'h3FF;
                4:       limit = -11'sd100;
                default: limit = 11'($urandom);
            endcase
            enable = (i != 4) && (i != 6);
            write_reg(sttd_pkg::REG_NEGATIVE_LIMIT, limit);
            write_reg(sttd_pkg::REG_TRIGGER_ENABLE, {10'd0, enable});
            run_random_phase(110);
            wait_idle();
        end
        write_reg(sttd_pkg::REG_NEGATIVE_LIMIT, -11'sd100);
        write_reg(sttd_pkg::REG_TRIGGER_ENABLE, 11'd1);
    endtask

    task automatic test_back_to_back();
        gaps_on  = 1'b0;
        stall_on = 1'b0;
        repeat (200) send_random_item();
        wait_idle();
    endtask

    task automatic test_output_stalls();
        gaps_on  = 1'b0;
        stall_on = 1'b1;
        repeat (200) send_random_item();
        wait_idle();
    endtask

    task automatic test_mixed_traffic();
        repeat (3)
        begin
            run_random_phase(180);
        end
        wait_idle();
    endtask

    initial
    begin
        clear_detector_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_field_extremes();
        test_limit_settings();
        test_back_to_back();
        test_output_stalls();
        test_mixed_traffic();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && readings_due.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
